/* rtl/flht_pkg.sv */
// shared types and constants for the fan level hysteresis table
`timescale 1ns / 1ps

package flht_pkg;

	localparam int LEVELS_DEF = 7;
	localparam int ROW_COUNT  = 7;
	localparam int PCT_W      = 7;
	localparam int RPM_W      = 13;
	localparam int LVL_W      = 3;
	localparam int ROW_W      = 27;
	localparam int CFG_IDX_W  = 3;

	localparam logic [PCT_W-1:0] MAX_PCT = 7'd100;

	// one table row, on threshold in the top bits
	typedef struct packed {
		logic [PCT_W-1:0] on;
		logic [PCT_W-1:0] off;
		logic [RPM_W-1:0] rpm;
	} row_t;

	// next level decision handed from the select logic to the top level
	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [PCT_W-1:0] pct;
		logic [RPM_W-1:0] rpm;
	} next_t;

	localparam row_t ROW_RESET [ROW_COUNT] = '{
		row_t'(27'd24576),
		row_t'(27'd33582008),
		row_t'(27'd68595116),
		row_t'(27'd78106328),
		row_t'(27'd86569064),
		row_t'(27'd96072084),
		row_t'(27'd105583396)
	};

endpackage

/* rtl/flht_regs.sv */
// table row registers written through the configuration port
`timescale 1ns / 1ps

module flht_regs
	import flht_pkg::*;
#(
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ROW_W-1:0]     cfg_data,
	output row_t                 rows [LEVELS]
);

	row_t rows_q [LEVELS];

	for (genvar k = 0; k < LEVELS; k++) begin : g_row
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rows_q[k] <= ROW_RESET[k];
			end else if (cfg_we && (cfg_index == CFG_IDX_W'(k))) begin
				rows_q[k] <= row_t'(cfg_data);
			end
		end
		assign rows[k] = rows_q[k];
	end

endmodule

/* rtl/flht_select.sv */
// next level pick: saturation, threshold compares and priority chains
`timescale 1ns / 1ps

module flht_select
	import flht_pkg::*;
#(
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic [PCT_W-1:0] pct_raw,
	input  logic [LVL_W-1:0] level_now,
	input  logic [PCT_W-1:0] last_demand,
	input  row_t             rows [LEVELS],
	output next_t            nxt
);

	localparam int IDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	logic [PCT_W-1:0] pct;
	logic [LVL_W-1:0] lvl_up;
	logic [LVL_W-1:0] lvl_dn;
	logic [LVL_W-1:0] lvl_sel;
	logic             climbing;
	logic             found;

	assign pct = (pct_raw > MAX_PCT) ? MAX_PCT : pct_raw;

	// climb through consecutive levels above the current one
	always_comb begin
		lvl_up   = level_now;
		climbing = 1'b1;
		for (int k = 1; k < LEVELS; k++) begin
			if ((LVL_W'(k) > level_now) && climbing) begin
				if (pct >= rows[k].on) begin
					lvl_up = LVL_W'(k);
				end else begin
					climbing = 1'b0;
				end
			end
		end
	end

	// highest level at or below the current one whose off threshold is exceeded
	always_comb begin
		lvl_dn = '0;
		found  = 1'b0;
		for (int j = LEVELS - 1; j > 0; j--) begin
			if ((LVL_W'(j) <= level_now) && !found && (pct > rows[j].off)) begin
				lvl_dn = LVL_W'(j);
				found  = 1'b1;
			end
		end
	end

	always_comb begin
		if (pct < last_demand) begin
			lvl_sel = lvl_dn;
		end else if (pct > last_demand) begin
			lvl_sel = lvl_up;
		end else begin
			lvl_sel = level_now;
		end
	end

	assign nxt.level = lvl_sel;
	assign nxt.pct   = pct;
	assign nxt.rpm   = rows[lvl_sel[IDX_W-1:0]].rpm;

endmodule

/* rtl/fan_level_hysteresis_table.sv */
// top level of the fan level hysteresis table
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  s_tdata: demand_pct
//  m_*       out        m_tvalid / m_tready  m_tdata: target_rpm, fan_level
//  cfg_*     in         cfg_we               cfg_index selects row, cfg_data row word
//
// one item per clock sustained while m_tready stays high; an input transfer loads the
// input register, which then loads the result register that drives m_tvalid
// the level and previous demand registers update as the result register loads,
// so the next item sees them with no bubble
// a stalled output holds the result register; the input register still takes
// one more transfer behind it
// reset clears the level, the previous demand and both valid flags, and loads
// the default table rows
`timescale 1ns / 1ps

module fan_level_hysteresis_table
	import flht_pkg::*;
#(
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [6:0] demand_pct, [7] zero
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // [12:0] target_rpm, [15:13] fan_level
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ROW_W-1:0]     cfg_data
);

	// table rows
	row_t rows [LEVELS];

	// input stage
	logic             valid_s1;
	logic [PCT_W-1:0] pct_s1;

	// result stage
	logic             valid_s2;
	logic [RPM_W-1:0] rpm_s2;
	logic [LVL_W-1:0] level_s2;

	// hysteresis state
	logic [LVL_W-1:0] level_q;
	logic [PCT_W-1:0] demand_q;

	next_t nxt;
	logic  advance;
	logic  s_fire;

	flht_regs #(
		.LEVELS(LEVELS)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rows     (rows)
	);

	flht_select #(
		.LEVELS(LEVELS)
	) u_select (
		.pct_raw    (pct_s1),
		.level_now  (level_q),
		.last_demand(demand_q),
		.rows       (rows),
		.nxt        (nxt)
	);

	// input stage moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			pct_s1 <= s_tdata[PCT_W-1:0];
		end
	end

	// state follows the item that enters the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			demand_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				level_q  <= nxt.level;
				demand_q <= nxt.pct;
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rpm_s2   <= nxt.rpm;
			level_s2 <= nxt.level;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {level_s2, rpm_s2};

`ifndef NO_ASSERTIONS
	// level state stays inside the table
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q < LVL_W'(LEVELS))
		else $error("level state beyond table");

	// stored demand is always saturated
	a_demand_sat: assert property (@(posedge clk) disable iff (!arst_n)
		demand_q <= MAX_PCT)
		else $error("stored demand above saturation limit");

	// the shown level and the level state agree after each load
	a_state_match: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (level_q == m_tdata[15:13]))
		else $error("result level differs from level state");

	// a full input stage behind a stalled result takes no transfer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |-> !s_tready)
		else $error("input stage accepts while blocked");
`endif

endmodule
